FILE: rtl/core/vtw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtw_pkg
// Shared types, walk-state codes and defaults for the traceback walker.
// ----------------------------------------------------------------------------
package vtw_pkg;

  localparam int unsigned LanesDefault = 4;
  localparam int unsigned RowsDefault  = 32;
  localparam int unsigned ColsDefault  = 32;
  localparam int unsigned MaxRes       = 63;

  // walk-state codes; MM..MI double as the step_state output codes
  localparam logic [2:0] W_MM   = 3'd0;
  localparam logic [2:0] W_GD   = 3'd1;
  localparam logic [2:0] W_IM   = 3'd2;
  localparam logic [2:0] W_DG   = 3'd3;
  localparam logic [2:0] W_MI   = 3'd4;
  localparam logic [2:0] W_BAD  = 3'd5;
  localparam logic [2:0] W_STOP = 3'd6;

  // stored mm_from codes
  localparam logic [2:0] C_STOP = 3'd0;
  localparam logic [2:0] C_MM   = 3'd1;
  localparam logic [2:0] C_GD   = 3'd2;
  localparam logic [2:0] C_IM   = 3'd3;
  localparam logic [2:0] C_DG   = 3'd4;
  localparam logic [2:0] C_MI   = 3'd5;

  // entry bit positions
  localparam int unsigned BitGd = 3;
  localparam int unsigned BitIm = 4;
  localparam int unsigned BitDg = 5;
  localparam int unsigned BitMi = 6;

  typedef struct packed {
    logic       en;
    logic [1:0] lane;
    logic [5:0] row;
    logic [5:0] col;
    logic [6:0] data;
  } vtw_wr_t;

  typedef struct packed {
    logic       en;
    logic [1:0] lane;
    logic [5:0] row;
    logic [5:0] col;
  } vtw_rd_t;

  typedef struct packed {
    logic [2:0] state;
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
    logic       bad;
    logic [5:0] count;
  } vtw_beat_t;

  function automatic logic [2:0] code_to_walk(input logic [2:0] code);
    logic [2:0] w;
    case (code)
      C_STOP:  w = W_STOP;
      C_MM:    w = W_MM;
      C_GD:    w = W_GD;
      C_IM:    w = W_IM;
      C_DG:    w = W_DG;
      C_MI:    w = W_MI;
      default: w = W_BAD;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/viterbi_traceback_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// viterbi_traceback_walker
// Sequencing: a write beat is taken whenever no walk is running; after a
//   trace beat is taken, each walk step reads its entry, then decides, and
//   the step is registered in the output stage. Steps are bounded by the
//   single memory read port; the input is stalled while a walk runs, at
//   most 63 steps, and output stalls stretch the walk.
// Reset: clears the sequencer and output valid; the entry memory is not
//   cleared and is undefined until written.
// ----------------------------------------------------------------------------
module viterbi_traceback_walker import vtw_pkg::*; #(
  parameter int unsigned LANES = LanesDefault,
  parameter int unsigned ROWS  = RowsDefault,
  parameter int unsigned COLS  = ColsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       opcode_i,
  input  wire logic [1:0] lane_i,
  input  wire logic [5:0] row_i,
  input  wire logic [5:0] col_i,
  input  wire logic [2:0] mm_from_i,
  input  wire logic       gd_from_match_i,
  input  wire logic       im_from_match_i,
  input  wire logic       dg_from_match_i,
  input  wire logic       mi_from_match_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      step_state_o,
  output logic [5:0]      step_row_o,
  output logic [5:0]      step_col_o,
  output logic            last_o,
  output logic            bad_state_o,
  output logic [5:0]      matched_count_o
);

  logic       busy;
  logic       in_acc;
  vtw_wr_t    wr;
  vtw_rd_t    rd;
  logic [6:0] rd_data;
  logic       out_free;
  logic       beat_valid;
  vtw_beat_t  beat;
  logic       out_valid_q;
  vtw_beat_t  out_q;

  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !busy;

  assign wr.en   = in_acc && !opcode_i;
  assign wr.lane = lane_i;
  assign wr.row  = row_i;
  assign wr.col  = col_i;
  assign wr.data = {mi_from_match_i, dg_from_match_i, im_from_match_i,
                    gd_from_match_i, mm_from_i};

  vtw_store #(
    .LANES(LANES),
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_i     (rd),
    .rd_data_o(rd_data)
  );

  vtw_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc && opcode_i),
    .start_lane_i(lane_i),
    .start_row_i (row_i),
    .start_col_i (col_i),
    .busy_o      (busy),
    .rd_o        (rd),
    .rd_data_i   (rd_data),
    .out_free_i  (out_free),
    .beat_valid_o(beat_valid),
    .beat_o      (beat)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (beat_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_valid) begin
      out_q <= beat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_state_o    = out_q.state;
  assign step_row_o      = out_q.row;
  assign step_col_o      = out_q.col;
  assign last_o          = out_q.last;
  assign bad_state_o     = out_q.bad;
  assign matched_count_o = out_q.count;

endmodule
`default_nettype wire

FILE: rtl/core/vtw_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtw_store
// Traceback entry memory, one write and one registered read port. Addresses
// outside the configured lanes, rows and columns are dropped on write and
// read back as zero.
// ----------------------------------------------------------------------------
module vtw_store import vtw_pkg::*; #(
  parameter int unsigned LANES = LanesDefault,
  parameter int unsigned ROWS  = RowsDefault,
  parameter int unsigned COLS  = ColsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire vtw_wr_t    wr_i,
  input  wire vtw_rd_t    rd_i,
  output logic [6:0]      rd_data_o
);

  localparam int unsigned Depth = LANES * ROWS * COLS;
  localparam int unsigned AW    = $clog2(Depth);

  logic [6:0]    mem_q [Depth];
  logic [6:0]    rd_data_q;
  logic          rd_ok_q;
  logic          wr_in_range;
  logic          rd_in_range;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_in_range = (32'(wr_i.lane) < LANES) && (wr_i.row != '0) &&
                       (32'(wr_i.row) <= ROWS) && (wr_i.col != '0) &&
                       (32'(wr_i.col) <= COLS);
  assign rd_in_range = (32'(rd_i.lane) < LANES) && (rd_i.row != '0) &&
                       (32'(rd_i.row) <= ROWS) && (rd_i.col != '0) &&
                       (32'(rd_i.col) <= COLS);

  assign wr_addr = AW'((32'(wr_i.lane) * ROWS + 32'(wr_i.row) - 32'd1) * COLS +
                       32'(wr_i.col) - 32'd1);
  assign rd_addr = AW'((32'(rd_i.lane) * ROWS + 32'(rd_i.row) - 32'd1) * COLS +
                       32'(rd_i.col) - 32'd1);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_range) begin
      mem_q[wr_addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en && rd_in_range) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else if (rd_i.en) begin
      rd_ok_q <= rd_in_range;
    end
  end

  assign rd_data_o = rd_ok_q ? rd_data_q : 7'd0;

endmodule
`default_nettype wire

FILE: rtl/core/vtw_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtw_walker
// Traceback sequencer: reads one entry per step, decides the predecessor
// state and hands one beat per step to the output stage.
// ----------------------------------------------------------------------------
module vtw_walker import vtw_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] start_lane_i,
  input  wire logic [5:0] start_row_i,
  input  wire logic [5:0] start_col_i,
  output logic            busy_o,
  output vtw_rd_t         rd_o,
  input  wire logic [6:0] rd_data_i,
  input  wire logic       out_free_i,
  output logic            beat_valid_o,
  output vtw_beat_t       beat_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EVAL = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] lane_q;
  logic [5:0] row_q, row_d;
  logic [5:0] col_q, col_d;
  logic [2:0] ws_q, ws_d;
  logic [5:0] tally_q, tally_d;
  logic [5:0] cnt_q;
  logic [2:0] nxt;
  logic       bad;
  logic       is_last;
  logic       emit;

  always_comb begin
    nxt     = ws_q;
    row_d   = row_q;
    col_d   = col_q;
    tally_d = tally_q;
    bad     = 1'b0;
    case (ws_q)
      W_MM: begin
        tally_d = tally_q + 6'd1;
        if (row_q <= 6'd1 || col_q <= 6'd1) begin
          nxt = W_STOP;
        end else begin
          nxt   = code_to_walk(rd_data_i[2:0]);
          row_d = row_q - 6'd1;
          col_d = col_q - 6'd1;
        end
      end
      W_GD, W_IM: begin
        if (col_q <= 6'd1) begin
          nxt = W_STOP;
        end else begin
          if (ws_q == W_GD ? rd_data_i[BitGd] : rd_data_i[BitIm]) begin
            nxt = W_MM;
          end
          col_d = col_q - 6'd1;
        end
      end
      W_DG, W_MI: begin
        if (row_q <= 6'd1) begin
          nxt = W_STOP;
        end else begin
          if (ws_q == W_DG ? rd_data_i[BitDg] : rd_data_i[BitMi]) begin
            nxt = W_MM;
          end
          row_d = row_q - 6'd1;
        end
      end
      default: begin
        bad = 1'b1;
        nxt = W_STOP;
      end
    endcase
  end

  assign is_last = (nxt == W_STOP) || (cnt_q == 6'(MaxRes - 1));
  assign emit    = (state_q == ST_EVAL) && out_free_i;
  assign ws_d    = nxt;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_READ;
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: if (emit) state_d = is_last ? ST_IDLE : ST_READ;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lane_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
      ws_q    <= W_MM;
      tally_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && start_i) begin
        lane_q  <= start_lane_i;
        row_q   <= start_row_i;
        col_q   <= start_col_i;
        ws_q    <= W_MM;
        tally_q <= '0;
        cnt_q   <= '0;
      end else if (emit) begin
        row_q   <= row_d;
        col_q   <= col_d;
        ws_q    <= is_last ? W_MM : ws_d;
        tally_q <= tally_d;
        cnt_q   <= cnt_q + 6'd1;
      end
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  assign rd_o.en   = (state_q == ST_READ);
  assign rd_o.lane = lane_q;
  assign rd_o.row  = row_q;
  assign rd_o.col  = col_q;

  assign beat_valid_o = emit;
  assign beat_o.state = is_last ? W_MM : ws_q;
  assign beat_o.row   = row_q;
  assign beat_o.col   = col_q;
  assign beat_o.last  = is_last;
  assign beat_o.bad   = is_last && bad;
  assign beat_o.count = is_last ? tally_d : 6'd0;

`ifndef SYNTHESIS
  a_beat_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_valid_o |-> state_q == ST_EVAL)
    else $error("beat outside evaluation");

  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVAL |-> $past(state_q) == ST_READ || $past(state_q) == ST_EVAL)
    else $error("evaluation without a preceding read");

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_valid_o && beat_o.last |=> state_q == ST_IDLE)
    else $error("walk continued after last beat");

  a_step_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> cnt_q <= 6'(MaxRes - 1))
    else $error("step count over cap");
`endif

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the traceback walker. A short table of directed
// beats covers the address extremes, every stored code and both values of
// each gap bit, then random writes and traceback walks are issued. Before
// each walk the cells it visits get random content, so no unwritten entry
// decides a step. Every step is checked against an in-bench walk predictor.
// ----------------------------------------------------------------------------
module testbench;
  import vtw_pkg::*;

  localparam logic       OpWrite   = 1'b0;
  localparam logic       OpTrace   = 1'b1;
  localparam logic [2:0] CodeBadLo = 3'd6;
  localparam logic [2:0] CodeBadHi = 3'd7;
  localparam int         NumDir    = 25;
  localparam int         NumRand   = 185;

  typedef struct packed {
    bit         typed;
    logic       op;
    logic [1:0] lane;
    logic [5:0] row;
    logic [5:0] col;
    logic [2:0] mm;
    logic       gd;
    logic       im;
    logic       dg;
    logic       mi;
    vtw_beat_t  want;
  } dir_row_t;

  // typed, op, lane, row, col, mm_from, gd, im, dg, mi, expected step
  localparam dir_row_t DirTab [NumDir] = '{
    '{1, OpTrace, 0, 0,  5,  C_STOP,    0, 0, 0, 0, '{W_MM, 0, 5, 1, 0, 1}},
    '{1, OpTrace, 1, 7,  0,  C_STOP,    0, 0, 0, 0, '{W_MM, 7, 0, 1, 0, 1}},
    '{1, OpTrace, 2, 1,  1,  C_STOP,    0, 0, 0, 0, '{W_MM, 1, 1, 1, 0, 1}},
    '{1, OpTrace, 3, 63, 63, C_STOP,    0, 0, 0, 0, '{W_MM, 63, 63, 1, 0, 1}},
    '{0, OpWrite, 0, 0,  3,  C_MM,      0, 0, 0, 0, '0},
    '{0, OpWrite, 3, 2,  2,  C_STOP,    1, 1, 1, 1, '0},
    '{1, OpTrace, 3, 2,  2,  C_STOP,    0, 0, 0, 0, '{W_MM, 2, 2, 1, 0, 1}},
    '{0, OpWrite, 3, 32, 32, CodeBadHi, 0, 0, 0, 0, '0},
    '{0, OpTrace, 3, 32, 32, C_STOP,    0, 0, 0, 0, '0},
    '{0, OpWrite, 0, 6,  6,  C_MM,      0, 0, 0, 0, '0},
    '{0, OpWrite, 0, 5,  5,  C_GD,      0, 0, 0, 0, '0},
    '{0, OpWrite, 0, 4,  4,  C_STOP,    0, 0, 0, 0, '0},
    '{0, OpWrite, 0, 4,  3,  C_STOP,    1, 0, 0, 0, '0},
    '{0, OpWrite, 0, 4,  2,  C_IM,      0, 0, 0, 0, '0},
    '{0, OpTrace, 0, 6,  6,  C_STOP,    0, 0, 0, 0, '0},
    '{0, OpWrite, 1, 5,  5,  C_DG,      0, 0, 0, 0, '0},
    '{0, OpWrite, 1, 4,  4,  C_STOP,    0, 0, 0, 0, '0},
    '{0, OpWrite, 1, 3,  4,  C_STOP,    0, 0, 1, 0, '0},
    '{0, OpWrite, 1, 2,  4,  C_MI,      0, 0, 0, 0, '0},
    '{0, OpTrace, 1, 5,  5,  C_STOP,    0, 0, 0, 0, '0},
    '{0, OpWrite, 2, 4,  4,  C_IM,      0, 0, 0, 0, '0},
    '{0, OpWrite, 2, 3,  3,  C_STOP,    0, 1, 0, 0, '0},
    '{0, OpWrite, 2, 3,  2,  C_MI,      0, 0, 0, 0, '0},
    '{0, OpWrite, 2, 2,  1,  C_STOP,    0, 0, 0, 1, '0},
    '{0, OpTrace, 2, 4,  4,  C_STOP,    0, 0, 0, 0, '0}
  };

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic       opcode_i        = 1'b0;
  logic [1:0] lane_i          = '0;
  logic [5:0] row_i           = '0;
  logic [5:0] col_i           = '0;
  logic [2:0] mm_from_i       = '0;
  logic       gd_from_match_i = 1'b0;
  logic       im_from_match_i = 1'b0;
  logic       dg_from_match_i = 1'b0;
  logic       mi_from_match_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic [2:0] step_state_o;
  logic [5:0] step_row_o;
  logic [5:0] step_col_o;
  logic       last_o;
  logic       bad_state_o;
  logic [5:0] matched_count_o;

  logic [6:0] cell_mem [LanesDefault][RowsDefault][ColsDefault];
  bit         cell_set [LanesDefault][RowsDefault][ColsDefault];
  vtw_beat_t  pending_steps [$];
  int         fail_count   = 0;
  bit         calm         = 1'b0;
  bit         hold_request = 1'b0;

  viterbi_traceback_walker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .lane_i          (lane_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .mm_from_i       (mm_from_i),
    .gd_from_match_i (gd_from_match_i),
    .im_from_match_i (im_from_match_i),
    .dg_from_match_i (dg_from_match_i),
    .mi_from_match_i (mi_from_match_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .step_state_o    (step_state_o),
    .step_row_o      (step_row_o),
    .step_col_o      (step_col_o),
    .last_o          (last_o),
    .bad_state_o     (bad_state_o),
    .matched_count_o (matched_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit on_grid(input logic [5:0] r, input logic [5:0] c);
    return r >= 6'd1 && r <= 6'(RowsDefault) && c >= 6'd1 && c <= 6'(ColsDefault);
  endfunction

  function automatic void store_cell(input logic [1:0] lane, input logic [5:0] r,
                                     input logic [5:0] c, input logic [6:0] ent);
    if (on_grid(r, c)) begin
      cell_mem[lane][r - 1][c - 1] = ent;
      cell_set[lane][r - 1][c - 1] = 1'b1;
    end
  endfunction

  // off-grid cells read as STOP; returns 0 for a cell never written
  function automatic bit fetch_cell(input logic [1:0] lane, input logic [5:0] r,
                                    input logic [5:0] c, output logic [6:0] ent);
    ent = '0;
    if (!on_grid(r, c)) return 1'b1;
    if (!cell_set[lane][r - 1][c - 1]) return 1'b0;
    ent = cell_mem[lane][r - 1][c - 1];
    return 1'b1;
  endfunction

  // Walks back from (r0, c0). Returns 1 with the position of the first
  // unwritten cell the walk needs; else queues the steps and returns 0.
  function automatic bit predict_walk(input logic [1:0] lane, input logic [5:0] r0,
                                      input logic [5:0] c0, output logic [5:0] miss_r,
                                      output logic [5:0] miss_c);
    vtw_beat_t  path [$];
    vtw_beat_t  b;
    logic [2:0] st;
    logic [2:0] nxt;
    logic [5:0] r;
    logic [5:0] c;
    logic [5:0] tally;
    logic [6:0] ent;
    bit         bad;
    r      = r0;
    c      = c0;
    st     = W_MM;
    tally  = '0;
    bad    = 1'b0;
    miss_r = '0;
    miss_c = '0;
    while (st != W_STOP && path.size() < MaxRes) begin
      b   = '{state: st, row: r, col: c, last: 1'b0, bad: 1'b0, count: '0};
      nxt = st;
      case (st)
        W_MM: begin
          tally = tally + 6'd1;
          if (r <= 6'd1 || c <= 6'd1) begin
            nxt = W_STOP;
          end else begin
            if (!fetch_cell(lane, r, c, ent)) begin
              miss_r = r;
              miss_c = c;
              return 1'b1;
            end
            case (ent[2:0])
              C_STOP:  nxt = W_STOP;
              C_MM:    nxt = W_MM;
              C_GD:    nxt = W_GD;
              C_IM:    nxt = W_IM;
              C_DG:    nxt = W_DG;
              C_MI:    nxt = W_MI;
              default: nxt = W_BAD;
            endcase
            r = r - 6'd1;
            c = c - 6'd1;
          end
        end
        W_GD, W_IM: begin
          if (c <= 6'd1) begin
            nxt = W_STOP;
          end else begin
            if (!fetch_cell(lane, r, c, ent)) begin
              miss_r = r;
              miss_c = c;
              return 1'b1;
            end
            if (ent[(st == W_GD) ? BitGd : BitIm]) nxt = W_MM;
            c = c - 6'd1;
          end
        end
        W_DG, W_MI: begin
          if (r <= 6'd1) begin
            nxt = W_STOP;
          end else begin
            if (!fetch_cell(lane, r, c, ent)) begin
              miss_r = r;
              miss_c = c;
              return 1'b1;
            end
            if (ent[(st == W_DG) ? BitDg : BitMi]) nxt = W_MM;
            r = r - 6'd1;
          end
        end
        default: begin
          bad = 1'b1;
          nxt = W_STOP;
        end
      endcase
      path.push_back(b);
      st = nxt;
    end
    b       = path.pop_back();
    b.state = W_MM;
    b.last  = 1'b1;
    b.bad   = bad;
    b.count = tally;
    path.push_back(b);
    foreach (path[i]) pending_steps.push_back(path[i]);
    return 1'b0;
  endfunction

  function automatic void note_fail(input string what, input vtw_beat_t want,
                                    input vtw_beat_t got);
    fail_count++;
    if (fail_count <= 10)
      $display({"%0t %s: want st=%0d r=%0d c=%0d last=%0b bad=%0b cnt=%0d",
                " | got st=%0d r=%0d c=%0d last=%0b bad=%0b cnt=%0d"},
               $time, what, want.state, want.row, want.col, want.last, want.bad,
               want.count, got.state, got.row, got.col, got.last, got.bad, got.count);
  endfunction

  task automatic send_beat(input logic op, input logic [1:0] lane, input logic [5:0] r,
                           input logic [5:0] c, input logic [6:0] ent);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    if (op == OpWrite) store_cell(lane, r, c, ent);
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    lane_i          <= lane;
    row_i           <= r;
    col_i           <= c;
    mm_from_i       <= ent[2:0];
    gd_from_match_i <= ent[BitGd];
    im_from_match_i <= ent[BitIm];
    dg_from_match_i <= ent[BitDg];
    mi_from_match_i <= ent[BitMi];
    do @(posedge clk_i); while (in_stall_o);
  endtask

  always @(posedge clk_i) begin
    vtw_beat_t got;
    vtw_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{state: step_state_o, row: step_row_o, col: step_col_o, last: last_o,
              bad: bad_state_o, count: matched_count_o};
      if (pending_steps.size() == 0) begin
        note_fail("unexpected step", '0, got);
      end else begin
        want = pending_steps.pop_front();
        if (got.state !== want.state || got.row !== want.row || got.col !== want.col ||
            got.last !== want.last || got.bad !== want.bad || got.count !== want.count)
          note_fail("step mismatch", want, got);
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 35);
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int         counted;
    int         k;
    int         wait_cnt;
    bit         drained;
    bit         held;
    logic [1:0] lane;
    logic [5:0] r;
    logic [5:0] c;
    logic [5:0] mr;
    logic [5:0] mc;
    logic [5:0] tmp;
    logic [2:0] mm;
    dir_row_t   d;
    counted = 0;
    drained = 1'b0;
    held    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) begin
      d = DirTab[i];
      if (d.op == OpTrace) begin
        if (d.typed) pending_steps.push_back(d.want);
        else void'(predict_walk(d.lane, d.row, d.col, mr, mc));
      end
      send_beat(d.op, d.lane, d.row, d.col, {d.mi, d.dg, d.im, d.gd, d.mm});
    end

    while (counted < NumRand) begin
      if (counted >= 60 && !drained) begin
        drained    = 1'b1;
        in_valid_i <= 1'b0;
        while (pending_steps.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      if (counted >= 100 && !held) begin
        held         = 1'b1;
        hold_request = 1'b1;
      end
      calm = (counted >= 130 && counted < 170);
      lane = 2'($urandom);
      k    = $urandom_range(99);
      if (k < 12) begin
        // walk starting off the grid
        r = $urandom_range(1) ? 6'd0 : 6'($urandom_range(33, 63));
        c = 6'($urandom_range(63));
        if ($urandom_range(1)) begin
          tmp = r;
          r   = c;
          c   = tmp;
        end
        void'(predict_walk(lane, r, c, mr, mc));
        send_beat(OpTrace, lane, r, c, '0);
        counted++;
      end else if (k < 22) begin
        r = 6'($urandom_range(63));
        c = 6'($urandom_range(63));
        send_beat(OpWrite, lane, r, c, 7'($urandom_range(127)));
        if (on_grid(r, c)) counted++;
      end else begin
        if ($urandom_range(3) != 0) begin
          r = 6'($urandom_range(1, 10));
          c = 6'($urandom_range(1, 10));
        end else begin
          r = 6'($urandom_range(1, 32));
          c = 6'($urandom_range(1, 32));
        end
        while (predict_walk(lane, r, c, mr, mc)) begin
          k = $urandom_range(99);
          if (k < 8) mm = C_STOP;
          else if (k < 38) mm = C_MM;
          else if (k < 50) mm = C_GD;
          else if (k < 62) mm = C_IM;
          else if (k < 74) mm = C_DG;
          else if (k < 86) mm = C_MI;
          else mm = (k < 93) ? CodeBadLo : CodeBadHi;
          send_beat(OpWrite, lane, mr, mc, {4'($urandom), mm});
          counted++;
        end
        send_beat(OpTrace, lane, r, c, '0);
        counted++;
      end
    end
    calm       = 1'b0;
    in_valid_i <= 1'b0;

    for (wait_cnt = 0; wait_cnt < 50000 && pending_steps.size() != 0; wait_cnt++)
      @(posedge clk_i);
    if (pending_steps.size() != 0) begin
      $display("%0d steps never arrived", pending_steps.size());
      fail_count += pending_steps.size();
    end
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: viterbi_traceback_walker.f
rtl/core/vtw_pkg.sv
rtl/core/vtw_store.sv
rtl/core/vtw_walker.sv
rtl/core/viterbi_traceback_walker.sv
tb/testbench.sv
